// File: src/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 10;

    localparam int CFG_W      = 4;
    localparam int AGE_W      = 16;
    localparam int CNT_W      = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int OUTCOME_W  = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CFG_W-1:0] FRAMES_RST = CFG_W'(3);
    localparam logic [AGE_W-1:0] AGE_MAX    = '1;
    localparam logic [CNT_W-1:0] CNT_MAX    = '1;

    localparam logic [OUTCOME_W-1:0] OUT_PRELOAD = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FAULT   = 2'd2;

    localparam logic REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: src/lrupr_ram.sv
`default_nettype none

module lrupr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/lru_page_replacement_unit.sv
// LRU page replacement unit. Each request carries one page reference and
// yields one result: preload into the next empty slot, hit, or fault with
// replacement of the oldest slot (lowest index on equal age), together with
// the saturating fault and reference totals. A preload completes in the
// cycle the request is accepted. A hit or fault walks the slot page/age RAM
// one slot per cycle over n slots, n being the active frame count (1 to
// min(FRAMES,15)), to age every slot, match the page and track the oldest
// entry, followed by a write-back in ST_DONE once the output is free. The
// input side stalls for the whole walk and while a result waits to be taken.
// frames_in_use lives at byte address 0 of the APB port.
`default_nettype none

module lru_page_replacement_unit
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PAGE_BITS-1:0]  i_page_number,

    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [OUTCOME_W-1:0]       o_outcome,
    output logic [SLOT_OUT_W-1:0]      o_slot_index,
    output logic [PAGE_BITS-1:0]       o_evicted_page,
    output logic [CNT_W-1:0]           o_fault_total,
    output logic [CNT_W-1:0]           o_reference_total,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic      [PDATA_W-1:0]    prdata,
    output logic                       pready
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int WORD_W = PAGE_BITS + AGE_W;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_frames;
    logic [CFG_W-1:0]      r_loaded, n_loaded;
    logic [CNT_W-1:0]      r_fault, n_fault;
    logic [CNT_W-1:0]      r_ref, n_ref;
    logic [CFG_W-1:0]      r_idx, n_idx;
    logic [SLOT_W-1:0]     r_pidx, n_pidx;
    logic                  r_pend, n_pend;
    logic                  r_found, n_found;
    logic [SLOT_W-1:0]     r_hit_idx, n_hit_idx;
    logic [SLOT_W-1:0]     r_best_idx, n_best_idx;
    logic [AGE_W-1:0]      r_best_age, n_best_age;
    logic [PAGE_BITS-1:0]  r_evict, n_evict;
    logic [PAGE_BITS-1:0]  r_page, n_page;
    logic                  r_out_valid, n_out_valid;
    logic [OUTCOME_W-1:0]  r_outcome, n_outcome;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [PAGE_BITS-1:0]  r_evicted, n_evicted;

    logic [CFG_W-1:0]      w_n;
    logic                  w_can_out;
    logic                  w_accept;
    logic                  w_preload;
    logic                  w_we;
    logic [SLOT_W-1:0]     w_waddr;
    logic [WORD_W-1:0]     w_wdata;
    logic [WORD_W-1:0]     w_rdata;
    logic [PAGE_BITS-1:0]  w_rd_page;
    logic [AGE_W-1:0]      w_rd_age;
    logic [AGE_W-1:0]      w_aged;

    always_comb begin
        if (r_frames == '0) begin
            w_n = CFG_W'(1);
        end else if (int'(r_frames) > FRAMES) begin
            w_n = CFG_W'(FRAMES);
        end else begin
            w_n = r_frames;
        end
    end

    assign w_can_out = !r_out_valid || !i_stall;
    assign o_stall   = !((r_state == ST_IDLE) && w_can_out);
    assign w_accept  = i_valid && !o_stall;
    assign w_preload = r_loaded < w_n;

    assign w_rd_page = w_rdata[AGE_W +: PAGE_BITS];
    assign w_rd_age  = w_rdata[AGE_W-1:0];
    assign w_aged    = (w_rd_age == AGE_MAX) ? w_rd_age : w_rd_age + AGE_W'(1);

    lrupr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAMES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (SLOT_W'(r_idx)),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = {r_page, {AGE_W{1'b0}}};
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_preload) begin
                    w_we    = 1'b1;
                    w_waddr = SLOT_W'(r_loaded);
                    w_wdata = {i_page_number, {AGE_W{1'b0}}};
                end
            end
            ST_SCAN: begin
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_pidx;
                    w_wdata = {w_rd_page, w_aged};
                end
            end
            ST_DONE: begin
                if (w_can_out) begin
                    w_we    = 1'b1;
                    w_waddr = r_found ? r_hit_idx : r_best_idx;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_fault     = r_fault;
        n_ref       = r_ref;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_pend      = r_pend;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_best_idx  = r_best_idx;
        n_best_age  = r_best_age;
        n_evict     = r_evict;
        n_page      = r_page;
        n_out_valid = r_out_valid && i_stall;
        n_outcome   = r_outcome;
        n_slot      = r_slot;
        n_evicted   = r_evicted;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_page = i_page_number;
                    if (w_preload) begin
                        n_out_valid = 1'b1;
                        n_outcome   = OUT_PRELOAD;
                        n_slot      = SLOT_W'(r_loaded);
                        n_evicted   = '0;
                        n_loaded    = r_loaded + CFG_W'(1);
                        n_ref       = (r_ref == CNT_MAX) ? r_ref : r_ref + CNT_W'(1);
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_found = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend) begin
                    if (!r_found && (w_rd_page == r_page)) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_pidx;
                    end
                    if ((r_pidx == '0) || (w_aged > r_best_age)) begin
                        n_best_age = w_aged;
                        n_best_idx = r_pidx;
                        n_evict    = w_rd_page;
                    end
                end
                if (r_idx < w_n) begin
                    n_pend = 1'b1;
                    n_pidx = SLOT_W'(r_idx);
                    n_idx  = r_idx + CFG_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_can_out) begin
                    n_out_valid = 1'b1;
                    n_ref       = (r_ref == CNT_MAX) ? r_ref : r_ref + CNT_W'(1);
                    if (r_found) begin
                        n_outcome = OUT_HIT;
                        n_slot    = r_hit_idx;
                        n_evicted = '0;
                    end else begin
                        n_outcome = OUT_FAULT;
                        n_slot    = r_best_idx;
                        n_evicted = r_evict;
                        n_fault   = (r_fault == CNT_MAX) ? r_fault : r_fault + CNT_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frames    <= FRAMES_RST;
            r_loaded    <= '0;
            r_fault     <= '0;
            r_ref       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_fault     <= n_fault;
            r_ref       <= n_ref;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE)) begin
                r_frames <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_hit_idx  <= n_hit_idx;
        r_best_idx <= n_best_idx;
        r_best_age <= n_best_age;
        r_evict    <= n_evict;
        r_page     <= n_page;
        r_outcome  <= n_outcome;
        r_slot     <= n_slot;
        r_evicted  <= n_evicted;
    end

    assign o_valid           = r_out_valid;
    assign o_outcome         = r_outcome;
    assign o_slot_index      = SLOT_OUT_W'(r_slot);
    assign o_evicted_page    = r_evicted;
    assign o_fault_total     = r_fault;
    assign o_reference_total = r_ref;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? PDATA_W'(r_frames) : '0;

    a_busy_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_preload) |=> o_stall)
        else $error("input taken during slot walk");

    a_faults_le_refs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fault_total <= o_reference_total))
        else $error("fault total above reference total");

    a_evict_only_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != OUT_FAULT)) |-> (o_evicted_page == '0))
        else $error("evicted page without a fault");

endmodule

`default_nettype wire

// File: bench/tb_lru_page_replacement_unit.sv
`default_nettype none

module tb_lru_page_replacement_unit
    import lrupr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES         = FRAMES_DEF;
    localparam int PAGE_BITS      = PAGE_BITS_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [OUTCOME_W-1:0]  outcome;
        logic [SLOT_OUT_W-1:0] slot;
        logic [PAGE_BITS-1:0]  evicted;
        logic [CNT_W-1:0]      faults;
        logic [CNT_W-1:0]      refs;
    } t_lru_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [PAGE_BITS-1:0]   i_page_number = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [OUTCOME_W-1:0]   o_outcome;
    logic [SLOT_OUT_W-1:0]  o_slot_index;
    logic [PAGE_BITS-1:0]   o_evicted_page;
    logic [CNT_W-1:0]       o_fault_total;
    logic [CNT_W-1:0]       o_reference_total;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    lru_page_replacement_unit #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_page_number     (i_page_number),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_outcome         (o_outcome),
        .o_slot_index      (o_slot_index),
        .o_evicted_page    (o_evicted_page),
        .o_fault_total     (o_fault_total),
        .o_reference_total (o_reference_total),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [PAGE_BITS-1:0] frame_page [FRAMES];
    logic [AGE_W-1:0]     frame_age [FRAMES] = '{default: '0};
    int                   frames_loaded = 0;
    logic [CNT_W-1:0]     fault_tally = '0;
    logic [CNT_W-1:0]     ref_tally = '0;
    logic [CFG_W-1:0]     frames_cfg = FRAMES_RST;

    t_lru_result pending_results [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    bit          long_hold_pending = 1'b0;
    int unsigned stall_left = 0;

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    function automatic t_lru_result predict_reference(input logic [PAGE_BITS-1:0] page);
        t_lru_result r;
        int          n;
        int          slot;
        bit          found;
        n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
        r = '0;
        if (ref_tally != CNT_MAX) ref_tally++;
        if (frames_loaded < n) begin
            r.outcome = OUT_PRELOAD;
            r.slot = SLOT_OUT_W'(frames_loaded);
            frame_page[frames_loaded] = page;
            frame_age[frames_loaded] = '0;
            frames_loaded++;
        end else begin
            found = 1'b0;
            slot = 0;
            for (int i = 0; i < n; i++) begin
                if (frame_age[i] != AGE_MAX) frame_age[i]++;
            end
            for (int i = n - 1; i >= 0; i--) begin
                if (frame_page[i] == page) begin
                    found = 1'b1;
                    slot = i;
                end
            end
            if (found) begin
                r.outcome = OUT_HIT;
            end else begin
                for (int i = 1; i < n; i++) begin
                    if (frame_age[i] > frame_age[slot]) slot = i;
                end
                r.outcome = OUT_FAULT;
                r.evicted = frame_page[slot];
                frame_page[slot] = page;
                if (fault_tally != CNT_MAX) fault_tally++;
            end
            frame_age[slot] = '0;
            r.slot = SLOT_OUT_W'(slot);
        end
        r.faults = fault_tally;
        r.refs = ref_tally;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_lru_result want;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                pending_results.push_back(predict_reference(i_page_number));
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result with no pending request: outcome %0d slot %0d",
                           o_outcome, o_slot_index);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("outcome", CNT_W'(want.outcome), CNT_W'(o_outcome));
                    check_field("slot_index", CNT_W'(want.slot), CNT_W'(o_slot_index));
                    check_field("evicted_page", CNT_W'(want.evicted), CNT_W'(o_evicted_page));
                    check_field("fault_total", want.faults, o_fault_total);
                    check_field("reference_total", want.refs, o_reference_total);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("lru_page_replacement_unit test failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall_left = LONG_HOLD;
        end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_reference(input logic [PAGE_BITS-1:0] page);
        int unsigned gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * REG_FRAMES_IN_USE);
        pwdata <= {(PDATA_W-CFG_W)'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        frames_cfg = value;
    endtask

    task automatic test_preload_and_replacement();
        send_reference('0);
        send_reference('0);
        send_reference('1);
        send_reference('0);
        send_reference(PAGE_BITS'(5));
        send_reference('1);
        wait_results_drained();
    endtask

    task automatic test_frame_count_range();
        write_frames_in_use(CFG_W'(0));
        send_reference(PAGE_BITS'(5));
        send_reference(PAGE_BITS'(5));
        wait_results_drained();
        write_frames_in_use('1);
        send_reference(PAGE_BITS'(10'h2AA));
        send_reference(PAGE_BITS'(10'h155));
        send_reference('1);
        send_reference(PAGE_BITS'(7));
        send_reference(PAGE_BITS'(8));
        send_reference(PAGE_BITS'(10'h155));
        send_reference(PAGE_BITS'(9));
        wait_results_drained();
        write_frames_in_use(CFG_W'(FRAMES));
        send_reference(PAGE_BITS'(10'h2AA));
        send_reference(PAGE_BITS'(11));
        wait_results_drained();
        write_frames_in_use(CFG_W'(2));
        send_reference(PAGE_BITS'(8));
        send_reference(PAGE_BITS'(12));
        send_reference(PAGE_BITS'(13));
        wait_results_drained();
    endtask

    task automatic test_random_references(input int total);
        logic [PAGE_BITS-1:0] pool [12];
        int                   sent;
        int                   phase;
        int                   phase_len;
        int                   pool_size;
        logic [CFG_W-1:0]     frames;
        sent = 0;
        phase = 0;
        while (sent < total) begin
            case (phase)
                0: frames = CFG_W'(1);
                1: frames = '1;
                2: frames = '0;
                3: frames = CFG_W'(FRAMES);
                default: frames = CFG_W'($urandom_range(0, 15));
            endcase
            write_frames_in_use(frames);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(1, 12);
            foreach (pool[k]) pool[k] = PAGE_BITS'($urandom);
            phase_len = $urandom_range(60, 200);
            for (int k = 0; k < phase_len && sent < total; k++) begin
                if ($urandom_range(0, 3) != 0)
                    send_reference(pool[$urandom_range(0, pool_size - 1)]);
                else
                    send_reference(PAGE_BITS'($urandom));
                sent++;
            end
            wait_results_drained();
            phase++;
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_full_backpressure();
        write_frames_in_use(CFG_W'(FRAMES));
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        long_hold_pending = 1'b1;
        for (int k = 0; k < 30; k++) send_reference(PAGE_BITS'($urandom_range(0, 11)));
        wait_results_drained();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        for (int k = 0; k < 10; k++) send_reference(PAGE_BITS'($urandom_range(0, 11)));
        wait_results_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_preload_and_replacement();
        test_frame_count_range();
        test_random_references(1480);
        test_full_backpressure();
        if (mismatch_count == 0)
            $display("lru_page_replacement_unit test passed");
        else
            $display("lru_page_replacement_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: lru_page_replacement_unit.f
src/lrupr_pkg.sv
src/lrupr_ram.sv
src/lru_page_replacement_unit.sv
bench/tb_lru_page_replacement_unit.sv
